// ----- hw/rtl/mbps_pkg.sv -----
package mbps_pkg;

	// pattern capacity and derived sizes
	localparam int MAX_PATTERN = 64;
	localparam int IDX_W       = 6;
	localparam int LEN_W       = 7;
	localparam int GRP         = 8;
	localparam int NGRP        = MAX_PATTERN / GRP;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = FIFO_AW + 1;
	localparam int DISP_BYTES  = 4;
	localparam int OFS_W       = 34;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_DATA = 3'd1,
		OP_SCAN = 3'd2,
		OP_SPAN = 3'd3,
		OP_END  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_LEN  = 2'd0,
		REG_MODE = 2'd1,
		REG_DISP = 2'd2
	} reg_idx_t;

	// broadcast control for the row of cells
	typedef struct packed {
		logic             shift;
		logic             load;
		logic [LEN_W-1:0] load_tgt;
		logic [7:0]       load_val;
		logic             load_care;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] dpos;
		logic             pat_shift;
	} cell_ctrl_t;

	// pattern realignment sweep toward cell 0
	typedef struct packed {
		logic       busy;
		logic       shift;
		logic [7:0] val;
		logic       care;
	} sweep_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] match;
		logic [63:0] target;
	} result_t;

endpackage

// ----- hw/rtl/mbps_in_if.sv -----
interface mbps_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [5:0]  pattern_index;
	logic [7:0]  pattern_value;
	logic        pattern_care;
	logic [7:0]  data_byte;
	logic [63:0] byte_address;

	modport source (
		output valid, opcode, pattern_index, pattern_value, pattern_care,
			data_byte, byte_address,
		input  ready
	);
	modport sink (
		input  valid, opcode, pattern_index, pattern_value, pattern_care,
			data_byte, byte_address,
		output ready
	);
endinterface

// ----- hw/rtl/mbps_out_if.sv -----
interface mbps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] match_address;
	logic [63:0] target_address;

	modport source (
		output valid, status, match_address, target_address,
		input  ready
	);
	modport sink (
		input  valid, status, match_address, target_address,
		output ready
	);
endinterface

// ----- hw/rtl/masked_byte_pattern_scanner.sv -----
// Masked byte pattern scanner. Takes one item per clock on the item channel and
// returns at most one result per item on the result channel, in order, through
// the pipeline registers and then an 8-entry output queue. Data bytes shift
// through a row of 64 cells, each comparing its window byte with a pattern byte
// aligned to it, so the window compare is done locally in each cell. A write of
// pattern_length starts a realignment that streams the pattern store into the
// row, one byte a cycle: for a length of 1..64 the item channel holds ready low
// from after the write until the sweep is done (other lengths need none).
// Ready also drops while the output queue together with the items in flight
// could overflow; a result sink that takes every cycle never causes that.
module masked_byte_pattern_scanner (
	input  logic       clk,
	input  logic       arst_n,
	mbps_in_if.sink    item,
	mbps_out_if.source result,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [6:0] wr_data
);
	import mbps_pkg::*;

	// configuration
	logic [LEN_W-1:0] len_q;
	logic             mode_q;
	logic [5:0]       off_q;
	logic             cfg_ok;

	// input side
	logic             in_xfer;
	opcode_t          op_in;
	logic [LEN_W-1:0] fill_q;
	cell_ctrl_t       ctrl;
	sweep_t           sw;
	logic [CNT_W-1:0] level;
	logic [CNT_W-1:0] pend;

	// row of cells
	logic [7:0]            win  [MAX_PATTERN];
	logic [7:0]            pat  [MAX_PATTERN];
	logic                  care [MAX_PATTERN];
	logic [3:0][7:0]       dsp  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] mis;

	// stage 1
	logic             v_s1;
	opcode_t          op_s1;
	logic [63:0]      addr_s1;
	logic [NGRP-1:0]  grp_mis;
	logic [3:0][7:0]  grp_disp [NGRP];
	logic [LEN_W-1:0] len_m1;

	// stage 2
	logic             v_s2;
	opcode_t          op_s2;
	logic [NGRP-1:0]  grp_mis_s2;
	logic [3:0][7:0]  grp_disp_s2 [NGRP];
	logic [63:0]      match_s2;
	logic             fill_ok_s2;
	logic             found_q;
	logic             found_d;
	logic             res_d;
	logic             hit;
	status_t          status_d;
	logic [3:0][7:0]  dsum;
	logic [31:0]      d32;
	logic [OFS_W-1:0] ofs_d;

	// stage 3
	logic             v_s3;
	logic             res_s3;
	status_t          status_s3;
	logic [63:0]      match_s3;
	logic [OFS_W-1:0] ofs_s3;
	logic             push;
	result_t          push_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			mode_q <= 1'b0;
			off_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_LEN:  len_q  <= wr_data;
				REG_MODE: mode_q <= wr_data[0];
				REG_DISP: off_q  <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg_ok = (len_q != '0) && (len_q <= LEN_W'(MAX_PATTERN))
		&& !(mode_q && (LEN_W'(off_q) + LEN_W'(DISP_BYTES) > len_q));

	// input handshake: hold off during realignment or when results could back up
	assign pend       = level + CNT_W'(v_s1) + CNT_W'(v_s2) + CNT_W'(v_s3);
	assign item.ready = !sw.busy && (pend < CNT_W'(FIFO_DEPTH));
	assign in_xfer    = item.valid && item.ready;
	assign op_in      = opcode_t'(item.opcode);
	assign len_m1     = len_q - LEN_W'(1);

	// cell broadcast control
	always_comb begin
		ctrl.shift     = in_xfer && (op_in == OP_DATA);
		ctrl.load      = in_xfer && (op_in == OP_LOAD);
		ctrl.load_tgt  = len_m1 - LEN_W'(item.pattern_index);
		ctrl.load_val  = item.pattern_value;
		ctrl.load_care = item.pattern_care;
		ctrl.len       = len_q;
		ctrl.dpos      = len_m1 - LEN_W'(off_q);
		ctrl.pat_shift = sw.shift;
	end

	mbps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_en     (ctrl.load),
		.ld_idx    (item.pattern_index),
		.ld_val    (item.pattern_value),
		.ld_care   (item.pattern_care),
		.start     (wr_en && (reg_idx_t'(wr_index) == REG_LEN)),
		.start_len (wr_data),
		.sw        (sw)
	);

	// cell 0 takes the newest byte and the sweep output; others take their neighbor
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [7:0] win_prev;
		logic [7:0] pat_prev;
		logic       care_prev;

		if (j == 0) begin : g_head
			assign win_prev  = item.data_byte;
			assign pat_prev  = sw.val;
			assign care_prev = sw.care;
		end else begin : g_body
			assign win_prev  = win[j-1];
			assign pat_prev  = pat[j-1];
			assign care_prev = care[j-1];
		end

		mbps_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.cell_idx  (LEN_W'(j)),
			.win_prev  (win_prev),
			.pat_prev  (pat_prev),
			.care_prev (care_prev),
			.win_q     (win[j]),
			.pat_q     (pat[j]),
			.care_q    (care[j]),
			.mismatch  (mis[j]),
			.disp      (dsp[j])
		);
	end

	// bytes seen in the current span, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_xfer) begin
			unique case (op_in)
				OP_DATA: begin
					if (fill_q < LEN_W'(MAX_PATTERN)) begin
						fill_q <= fill_q + LEN_W'(1);
					end
				end
				OP_SCAN, OP_SPAN: fill_q <= '0;
				default: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op_in;
		addr_s1 <= item.byte_address;
	end

	// first level of the reduction tree, groups of GRP cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_mis[g]  = 1'b0;
			grp_disp[g] = '0;
			for (int e = 0; e < GRP; e++) begin
				grp_mis[g]  = grp_mis[g] | mis[g*GRP+e];
				grp_disp[g] = grp_disp[g] | dsp[g*GRP+e];
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s2       <= op_s1;
		grp_mis_s2  <= grp_mis;
		grp_disp_s2 <= grp_disp;
		match_s2    <= addr_s1 - 64'(len_m1);
		fill_ok_s2  <= (fill_q >= len_q);
	end

	// stage 2: final reduction, scan state and result decision
	always_comb begin
		dsum = '0;
		for (int g = 0; g < NGRP; g++) begin
			dsum = dsum | grp_disp_s2[g];
		end
		d32   = {dsum[3], dsum[2], dsum[1], dsum[0]};
		ofs_d = mode_q ? ({{(OFS_W-32){d32[31]}}, d32} + OFS_W'(off_q)
			+ OFS_W'(DISP_BYTES)) : '0;

		found_d  = found_q;
		res_d    = 1'b0;
		hit      = 1'b0;
		status_d = ST_FOUND;
		if (v_s2) begin
			unique case (op_s2)
				OP_SCAN: begin
					found_d  = !cfg_ok;
					res_d    = !cfg_ok;
					status_d = ST_INVALID;
				end
				OP_END: begin
					if (!found_q) begin
						found_d  = 1'b1;
						res_d    = 1'b1;
						status_d = cfg_ok ? ST_NOTFOUND : ST_INVALID;
					end
				end
				OP_DATA: begin
					if (!found_q && cfg_ok && fill_ok_s2 && !(|grp_mis_s2)) begin
						found_d = 1'b1;
						res_d   = 1'b1;
						hit     = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		res_s3    <= res_d;
		status_s3 <= status_d;
		match_s3  <= hit ? match_s2 : 64'h0;
		ofs_s3    <= hit ? ofs_d : '0;
	end

	// stage 3: target address add, then into the output queue
	always_comb begin
		push             = v_s3 && res_s3;
		push_data.status = status_s3;
		push_data.match  = match_s3;
		push_data.target = match_s3 + {{(64-OFS_W){ofs_s3[OFS_W-1]}}, ofs_s3};
	end

	mbps_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.result    (result),
		.level     (level)
	);

endmodule

// ----- hw/rtl/mbps_cell.sv -----
module mbps_cell (
	input  logic                       clk,
	input  mbps_pkg::cell_ctrl_t       ctrl,
	input  logic [mbps_pkg::LEN_W-1:0] cell_idx,
	input  logic [7:0]                 win_prev,
	input  logic [7:0]                 pat_prev,
	input  logic                       care_prev,
	output logic [7:0]                 win_q,
	output logic [7:0]                 pat_q,
	output logic                       care_q,
	output logic                       mismatch,
	output logic [3:0][7:0]            disp
);
	import mbps_pkg::*;

	logic [LEN_W-1:0] diff;

	// window byte moves one cell older per data byte
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			win_q <= win_prev;
		end
	end

	// aligned pattern byte: sweep shift or a direct load, never both at once
	always_ff @(posedge clk) begin
		if (ctrl.pat_shift) begin
			pat_q  <= pat_prev;
			care_q <= care_prev;
		end else if (ctrl.load && ctrl.load_tgt == cell_idx) begin
			pat_q  <= ctrl.load_val;
			care_q <= ctrl.load_care;
		end
	end

	// local compare and displacement tap
	always_comb begin
		diff     = ctrl.dpos - cell_idx;
		mismatch = (cell_idx < ctrl.len) && care_q && (win_q != pat_q);
		for (int k = 0; k < DISP_BYTES; k++) begin
			disp[k] = (diff == LEN_W'(k)) ? win_q : 8'h00;
		end
	end

endmodule

// ----- hw/rtl/mbps_seq.sv -----
module mbps_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ld_en,
	input  logic [mbps_pkg::IDX_W-1:0] ld_idx,
	input  logic [7:0]                 ld_val,
	input  logic                       ld_care,
	input  logic                       start,
	input  logic [mbps_pkg::LEN_W-1:0] start_len,
	output mbps_pkg::sweep_t           sw
);
	import mbps_pkg::*;

	logic [8:0]       mem [MAX_PATTERN];
	logic [8:0]       rd_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] n_q;
	logic             active_q;
	logic             rvld_q;

	// pattern store, indexed by pattern position
	always_ff @(posedge clk) begin
		if (ld_en) begin
			mem[ld_idx] <= {ld_care, ld_val};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[cnt_q[IDX_W-1:0]];
	end

	// sweep: read positions 0..len-1, each pushed into cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rvld_q   <= 1'b0;
			cnt_q    <= '0;
			n_q      <= '0;
		end else if (start) begin
			active_q <= (start_len != '0) && (start_len <= LEN_W'(MAX_PATTERN));
			rvld_q   <= 1'b0;
			cnt_q    <= '0;
			n_q      <= start_len;
		end else if (active_q) begin
			rvld_q <= 1'b1;
			cnt_q  <= cnt_q + LEN_W'(1);
			if (cnt_q + LEN_W'(1) == n_q) begin
				active_q <= 1'b0;
			end
		end else begin
			rvld_q <= 1'b0;
		end
	end

	always_comb begin
		sw.busy  = active_q || rvld_q;
		sw.shift = rvld_q;
		sw.val   = rd_q[7:0];
		sw.care  = rd_q[8];
	end

endmodule

// ----- hw/rtl/mbps_ofifo.sv -----
module mbps_ofifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mbps_pkg::result_t          push_data,
	mbps_out_if.source                 result,
	output logic [mbps_pkg::CNT_W-1:0] level
);
	import mbps_pkg::*;

	result_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;
	result_t            head;

	assign pop  = result.valid && result.ready;
	assign head = fifo_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_comb begin
		result.valid          = (cnt_q != '0);
		result.status         = head.status;
		result.match_address  = head.match;
		result.target_address = head.target;
		level                 = cnt_q;
	end

endmodule

// ----- hw/rtl/mbps_chk.sv -----
module mbps_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [63:0] match_address,
	input logic [63:0] target_address,
	input logic        wr_en,
	input logic [1:0]  wr_index,
	input logic [6:0]  wr_data
);
	import mbps_pkg::*;

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			$stable(status) && $stable(match_address) && $stable(target_address))
		else $error("result payload changed while stalled");

	// only a match carries addresses
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_FOUND) |->
			(match_address == 64'h0) && (target_address == 64'h0))
		else $error("non-match result with nonzero address");

	// a usable length write starts realignment, which blocks items
	a_realign_block: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (wr_index == REG_LEN) && (wr_data != 7'd0)
			&& (wr_data <= 7'(MAX_PATTERN)) |=> !item_ready)
		else $error("item channel ready during pattern realignment");

endmodule

bind masked_byte_pattern_scanner mbps_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_ready     (item.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.status         (result.status),
	.match_address  (result.match_address),
	.target_address (result.target_address),
	.wr_en          (wr_en),
	.wr_index       (wr_index),
	.wr_data        (wr_data)
);
